// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock outside reset
`define AST_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define AST_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== hdl/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// types and constants of the huffman code bit packer
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int SYMBOLS      = 128;
  localparam int MAX_CODE_LEN = 32;
  localparam int SYM_W        = 7;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int PCNT_W       = 4;
  localparam int WIN_W        = BYTE_W + CODE_W;
  localparam int SH_W         = 6;
  localparam int IN_TDATA_W   = 48;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] addr;
    entry_t           entry;
  } tbl_wr_t;

endpackage

// ===== hdl/hcbp_code_table.sv =====
// ----------------------------------------------------------------------------
// hcbp_code_table
// code memory with per-entry valid bits; unwritten entries read as length zero
// ----------------------------------------------------------------------------
module hcbp_code_table
  import hcbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  tbl_wr_t          wr,
  input  logic             rd_en,
  input  logic [SYM_W-1:0] rd_addr,
  output entry_t           rd_entry
);

  entry_t       mem [SYMBOLS];
  logic         vld [SYMBOLS];
  entry_t       rd_data;
  logic         rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SYMBOLS; i++) begin
        vld[i] <= 1'b0;
      end
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  always_comb begin
    rd_entry = rd_data;
    if (!rd_vld) begin
      rd_entry.len = '0;
    end
  end

endmodule

// ===== hdl/hcbp_shift.sv =====
// ----------------------------------------------------------------------------
// hcbp_shift
// shared left shifter for code alignment and byte extraction
// ----------------------------------------------------------------------------
module hcbp_shift
  import hcbp_pkg::*;
(
  input  logic [WIN_W-1:0] din,
  input  logic [SH_W-1:0]  shamt,
  output logic [WIN_W-1:0] dout
);

  assign dout = din << shamt;

endmodule

// ===== hdl/huffman_code_bit_packer.sv =====
// load: request taken, then S_LOAD writes the table and sends the result byte
// encode: request, table read, merge, one byte per unstalled cycle; no output if absent
// finish: request, data byte, pad byte; one request at a time
// the rate is set by the shared 40-bit shifter, used once per byte
// rst is synchronous; it empties the bit buffer and marks all codes absent
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// packs prefix codes from a loadable table into a byte stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_code_bit_packer
  import hcbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // symbol[6:0], code_bits[38:7], code_length[44:39], zero fill
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_byte[7:0]
  output logic [BYTE_W-1:0]     m_axis_tdata,
  output logic                  m_axis_tlast,
  // load_rejected[0]
  output logic                  m_axis_tuser
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_LOAD     = 7'b0000010,
    S_FETCH    = 7'b0000100,
    S_EMIT     = 7'b0001000,
    S_FIN_DATA = 7'b0010000,
    S_FIN_PAD  = 7'b0100000,
    S_SPARE    = 7'b1000000
  } state_t;

  state_t               state;
  logic [SYM_W-1:0]     itm_sym;
  logic [CODE_W-1:0]    itm_code;
  logic [LEN_W-1:0]     itm_len;
  logic [BYTE_W-1:0]    pend;
  logic [PCNT_W-1:0]    pend_cnt;
  logic [WIN_W-1:0]     win;
  logic [SH_W-1:0]      cnt;
  logic                 out_vld;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_last;
  logic                 out_rej;

  logic                 slot_free;
  logic                 in_fire;
  tbl_wr_t              tbl_wr;
  entry_t               rd_entry;
  logic [WIN_W-1:0]     sh_in;
  logic [SH_W-1:0]      sh_amt;
  logic [WIN_W-1:0]     sh_out;
  logic [PCNT_W-1:0]    pad;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_vld || m_axis_tready;
  assign pad           = PCNT_W'(BYTE_W) - pend_cnt;

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_rej;

  // table write on load
  always_comb begin
    tbl_wr.en         = (state == S_LOAD) && slot_free && (itm_len <= LEN_W'(MAX_CODE_LEN));
    tbl_wr.addr       = itm_sym;
    tbl_wr.entry.len  = itm_len;
    tbl_wr.entry.code = itm_code & ~({CODE_W{1'b1}} << itm_len);
  end

  hcbp_code_table u_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (tbl_wr),
    .rd_en    (in_fire),
    .rd_addr  (s_axis_tdata[SYM_W-1:0]),
    .rd_entry (rd_entry)
  );

  // shifter: align new code behind pending bits, or move next byte to the top
  always_comb begin
    if (state == S_EMIT) begin
      sh_in  = win;
      sh_amt = SH_W'(BYTE_W);
    end else begin
      sh_in  = {{BYTE_W{1'b0}}, rd_entry.code};
      sh_amt = SH_W'(WIN_W) - SH_W'(pend_cnt) - rd_entry.len;
    end
  end

  hcbp_shift u_shift (
    .din   (sh_in),
    .shamt (sh_amt),
    .dout  (sh_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_vld  <= 1'b0;
      pend     <= '0;
      pend_cnt <= '0;
    end else begin
      if (m_axis_tready) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            itm_sym  <= s_axis_tdata[SYM_W-1:0];
            itm_code <= s_axis_tdata[SYM_W +: CODE_W];
            itm_len  <= s_axis_tdata[SYM_W+CODE_W +: LEN_W];
            unique case (op_t'(s_axis_tuser))
              OP_LOAD:   state <= S_LOAD;
              OP_ENCODE: state <= S_FETCH;
              OP_FINISH: state <= S_FIN_DATA;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: begin
          if (slot_free) begin
            out_vld  <= 1'b1;
            out_byte <= '0;
            out_last <= 1'b1;
            out_rej  <= (itm_len > LEN_W'(MAX_CODE_LEN));
            state    <= S_IDLE;
          end
        end
        S_FETCH: begin
          if (rd_entry.len == '0) begin
            state <= S_IDLE;
          end else begin
            win   <= sh_out | {pend, {CODE_W{1'b0}}};
            cnt   <= SH_W'(pend_cnt) + rd_entry.len;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (cnt > SH_W'(BYTE_W)) begin
            if (slot_free) begin
              out_vld  <= 1'b1;
              out_byte <= win[WIN_W-1 -: BYTE_W];
              out_last <= (cnt <= SH_W'(2 * BYTE_W));
              out_rej  <= 1'b0;
              win      <= sh_out;
              cnt      <= cnt - SH_W'(BYTE_W);
            end
          end else begin
            pend     <= win[WIN_W-1 -: BYTE_W];
            pend_cnt <= cnt[PCNT_W-1:0];
            state    <= S_IDLE;
          end
        end
        S_FIN_DATA: begin
          if (slot_free) begin
            out_vld  <= 1'b1;
            out_byte <= pend;
            out_last <= 1'b0;
            out_rej  <= 1'b0;
            state    <= S_FIN_PAD;
          end
        end
        S_FIN_PAD: begin
          if (slot_free) begin
            out_vld  <= 1'b1;
            out_byte <= {{(BYTE_W-PCNT_W){1'b0}}, pad};
            out_last <= 1'b1;
            out_rej  <= 1'b0;
            pend     <= '0;
            pend_cnt <= '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // pending bits are left aligned with zeros below the count
  `AST_NEVER(a_pend_cnt_range, clk, rst, pend_cnt > PCNT_W'(BYTE_W), "pending count above 8")
  `AST_HOLDS(a_pend_low_zero, clk, rst, (pend & (8'hFF >> pend_cnt)) == 8'h00,
             "stray pending bits")
  `AST_HOLDS(a_emit_cnt_range, clk, rst, (state != S_EMIT) || (cnt <= SH_W'(WIN_W)),
             "window overflow")
  `AST_HOLDS(a_fin_pad_follows, clk, rst,
             (state != S_FIN_PAD) || ($past(state) == S_FIN_DATA) || ($past(state) == S_FIN_PAD),
             "pad byte without data byte")

endmodule
